### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication property on every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

### rtl/core/psu_pkg.sv
// Shared constants, types and register codes of the scanline unfilter
`default_nettype none

package psu_pkg;

  localparam int MAX_ROW_PIXELS  = 2048;
  localparam int MAX_PIXEL_BYTES = 4;
  localparam int STORE_DEPTH     = MAX_ROW_PIXELS * MAX_PIXEL_BYTES;
  localparam int COL_W           = $clog2(STORE_DEPTH);
  localparam int ROW_BYTES_W     = COL_W + 1;
  localparam int BPP_IDX_W       = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

  // Configuration register indexes
  localparam logic [1:0] CFG_ROW_PIXELS      = 2'd0;
  localparam logic [1:0] CFG_BYTES_PER_PIXEL = 2'd1;
  localparam logic [1:0] CFG_IMAGE_ROWS      = 2'd2;

  // Highest legal row filter code
  localparam logic [7:0] FILT_MAX_CODE = 8'd4;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_BAD   = 1'b1
  } op_kind_t;

  typedef struct packed {
    logic [11:0] row_pixels;
    logic [2:0]  bytes_per_pixel;
    logic [15:0] image_rows;
  } cfg_t;

  // One classified transaction passed from the front to the back
  typedef struct packed {
    op_kind_t             kind;
    logic [7:0]           data;
    filt_t                filt;
    logic [COL_W-1:0]     col;
    logic                 first_row;
    logic                 col_ge_bpp;
    logic [BPP_IDX_W-1:0] bpp_idx;
    logic                 done;
  } psu_op_t;

endpackage

`default_nettype wire

### rtl/core/psu_front.sv
// Front end: accepts stream bytes, tracks row and column position, classifies
`default_nettype none

module psu_front
  import psu_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire logic [7:0] stream_byte,
  input  wire logic    q_full,
  output logic         q_push,
  output psu_op_t      q_op,
  output logic         halted
);

  logic                   awaiting;
  filt_t                  filt;
  logic [COL_W-1:0]       col;
  logic [15:0]            row;

  logic [11:0]            eff_pix;
  logic [2:0]             eff_bpp;
  logic [15:0]            eff_rows;
  logic [ROW_BYTES_W-1:0] row_bytes;
  logic                   accept;
  logic                   bad_code;
  logic                   row_end;
  logic                   img_end;

  // Clamp the register values to their legal ranges
  always_comb begin
    if (cfg.row_pixels == 12'd0) begin
      eff_pix = 12'd1;
    end else if (cfg.row_pixels > 12'(MAX_ROW_PIXELS)) begin
      eff_pix = 12'(MAX_ROW_PIXELS);
    end else begin
      eff_pix = cfg.row_pixels;
    end
    if (cfg.bytes_per_pixel == 3'd0) begin
      eff_bpp = 3'd1;
    end else if (cfg.bytes_per_pixel > 3'(MAX_PIXEL_BYTES)) begin
      eff_bpp = 3'(MAX_PIXEL_BYTES);
    end else begin
      eff_bpp = cfg.bytes_per_pixel;
    end
    eff_rows = (cfg.image_rows == 16'd0) ? 16'd1 : cfg.image_rows;
  end

  assign row_bytes = ROW_BYTES_W'(eff_pix) * ROW_BYTES_W'(eff_bpp);

  // Classify the byte on the input
  assign in_ready = halted || !q_full;
  assign accept   = in_valid && in_ready;
  assign bad_code = stream_byte > FILT_MAX_CODE;
  assign row_end  = ({1'b0, col} + ROW_BYTES_W'(1)) >= row_bytes;
  assign img_end  = ({1'b0, row} + 17'd1) >= {1'b0, eff_rows};
  assign q_push   = accept && !halted && (!awaiting || bad_code);

  always_comb begin
    q_op.kind       = awaiting ? OP_BAD : OP_PIXEL;
    q_op.data       = stream_byte;
    q_op.filt       = filt;
    q_op.col        = col;
    q_op.first_row  = (row == 16'd0);
    q_op.col_ge_bpp = col >= COL_W'(eff_bpp);
    q_op.bpp_idx    = BPP_IDX_W'(eff_bpp - 3'd1);
    q_op.done       = row_end && img_end;
  end

  // Advance the position counters on every accepted transaction until the front halts
  always_ff @(posedge clk) begin
    if (rst) begin
      halted   <= 1'b0;
      awaiting <= 1'b1;
      filt     <= FILT_NONE;
      col      <= '0;
      row      <= '0;
    end else if (accept && !halted) begin
      if (awaiting) begin
        if (bad_code) begin
          halted <= 1'b1;
        end else begin
          filt     <= filt_t'(stream_byte[2:0]);
          awaiting <= 1'b0;
        end
      end else if (row_end) begin
        col      <= '0;
        awaiting <= 1'b1;
        row      <= img_end ? 16'd0 : row + 16'd1;
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/psu_queue.sv
// Short queue of classified transactions between the front and the back
`default_nettype none

module psu_queue
  import psu_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire psu_op_t push_op,
  output logic         full,
  input  wire logic    pop,
  output logic         head_valid,
  output psu_op_t      head_op
);

  psu_op_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_op    = entries[rd_ptr];

  // Hold the payloads
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  // Advance the pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/psu_back.sv
// Back end: line store read, filter reconstruction and output register
`default_nettype none

module psu_back
  import psu_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    head_valid,
  input  wire psu_op_t head_op,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_ready,
  output logic [7:0]   pixel_byte,
  output logic         image_done,
  output logic         bad_filter
);

  logic [7:0] line_store [STORE_DEPTH];
  logic [7:0] rd_data;
  logic [7:0] last_r;
  logic [7:0] left_hist [MAX_PIXEL_BYTES];
  logic [7:0] ul_hist   [MAX_PIXEL_BYTES];

  psu_op_t    ex_op;
  logic       ex_valid;
  logic       ex_fwd;
  logic       ex_fire;
  logic       ex_free;
  logic       fwd_hit;

  logic [7:0]  a;
  logic [7:0]  b;
  logic [7:0]  c;
  logic [8:0]  avg_sum;
  logic signed [10:0] pa_s;
  logic signed [10:0] pb_s;
  logic signed [10:0] pc_s;
  logic [9:0]  pa;
  logic [9:0]  pb;
  logic [9:0]  pc;
  logic [7:0]  pred;
  logic [7:0]  r;

  assign ex_fire = ex_valid && (!out_valid || out_ready);
  assign ex_free = !ex_valid || ex_fire;
  assign pop     = head_valid && ex_free;
  // The entry being written this cycle is read stale: take it from last_r instead
  assign fwd_hit = ex_fire && (ex_op.kind == OP_PIXEL) && (ex_op.col == head_op.col);

  // Issue the line store read as the transaction enters the execute stage
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data <= line_store[head_op.col];
      ex_op   <= head_op;
      ex_fwd  <= fwd_hit;
    end
    if (ex_fire && ex_op.kind == OP_PIXEL) begin
      line_store[ex_op.col] <= r;
      last_r                <= r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (ex_free) begin
      ex_valid <= head_valid;
    end
  end

  // Gather the neighbours
  always_comb begin
    a = ex_op.col_ge_bpp ? left_hist[ex_op.bpp_idx] : 8'd0;
    if (ex_op.first_row) begin
      b = 8'd0;
    end else begin
      b = ex_fwd ? last_r : rd_data;
    end
    c = (!ex_op.first_row && ex_op.col_ge_bpp) ? ul_hist[ex_op.bpp_idx] : 8'd0;
  end

  // Paeth distances
  always_comb begin
    pa_s = 11'(signed'({3'b000, b})) - 11'(signed'({3'b000, c}));
    pb_s = 11'(signed'({3'b000, a})) - 11'(signed'({3'b000, c}));
    pc_s = pa_s + pb_s;
    pa   = pa_s[10] ? 10'(-pa_s) : pa_s[9:0];
    pb   = pb_s[10] ? 10'(-pb_s) : pb_s[9:0];
    pc   = pc_s[10] ? 10'(-pc_s) : pc_s[9:0];
    avg_sum = {1'b0, a} + {1'b0, b};
  end

  // Select the predictor for the row's filter
  always_comb begin
    case (ex_op.filt)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:    pred = 8'd0;
    endcase
    r = ex_op.data + pred;
  end

  // Shift the left and upper-left histories
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i] <= 8'd0;
        ul_hist[i]   <= 8'd0;
      end
    end else if (ex_fire && ex_op.kind == OP_PIXEL) begin
      for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
        left_hist[i] <= left_hist[i-1];
        ul_hist[i]   <= ul_hist[i-1];
      end
      left_hist[0] <= r;
      ul_hist[0]   <= b;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ex_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      if (ex_op.kind == OP_BAD) begin
        pixel_byte <= 8'd0;
        image_done <= 1'b0;
        bad_filter <= 1'b1;
      end else begin
        pixel_byte <= r;
        image_done <= ex_op.done;
        bad_filter <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/png_scanline_unfilter.sv
// An accepted data byte is registered in a queue entry, the execute stage and the
// output register. Throughput: one stream byte per cycle, filter type bytes
// included, while the queue is not full; the left neighbour feedback through the
// execute stage sets this rate. The line store is a single-port-write, single-read
// memory with a registered read. Reset clears counters, queue and histories; the
// line store is not cleared, as the first row of an image never uses it.
`default_nettype none

`include "assert_macros.svh"

module png_scanline_unfilter
  import psu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  stream_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       pixel_byte,
  output logic             image_done,
  output logic             bad_filter
);

  cfg_t    cfg;
  logic    q_full;
  logic    q_push;
  psu_op_t q_op;
  logic    q_pop;
  logic    head_valid;
  psu_op_t head_op;
  logic    halted;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_pixels      <= 12'd1;
      cfg.bytes_per_pixel <= 3'd4;
      cfg.image_rows      <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROW_PIXELS:      cfg.row_pixels      <= cfg_data[11:0];
        CFG_BYTES_PER_PIXEL: cfg.bytes_per_pixel <= cfg_data[2:0];
        CFG_IMAGE_ROWS:      cfg.image_rows      <= cfg_data;
        default:             ;
      endcase
    end
  end

  psu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream_byte (stream_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_op        (q_op),
    .halted      (halted)
  );

  psu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_op    (q_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  psu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_byte (pixel_byte),
    .image_done (image_done),
    .bad_filter (bad_filter)
  );

  `ASSERT_NEVER(a_push_when_full, clk, rst, q_push && q_full)
  `ASSERT_NEVER(a_push_when_halted, clk, rst, q_push && halted)
  `ASSERT_NEVER(a_pop_when_empty, clk, rst, q_pop && !head_valid)
  `ASSERT_PROP(a_bad_result_form, clk, rst, (out_valid && bad_filter) |-> (pixel_byte == 8'd0 && !image_done))

endmodule

`default_nettype wire

### test/png_scanline_unfilter_tb.sv
// Self-checking testbench for png_scanline_unfilter: random images against a local predictor
`default_nettype none

module png_scanline_unfilter_tb
  import psu_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int ITEM_TARGET    = 850;
  localparam int TAIL_ITEMS     = 120;

  // One pending transaction: a register write or a stream byte
  typedef struct {
    bit          is_reg;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    logic [7:0]  data;
  } stim_t;

  // One reconstructed byte as the block should deliver it
  typedef struct {
    logic [7:0] pix;
    logic       done;
    logic       bad;
  } pixel_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  stream_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  pixel_byte;
  logic        image_done;
  logic        bad_filter;

  png_scanline_unfilter u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .stream_byte (stream_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_byte  (pixel_byte),
    .image_done  (image_done),
    .bad_filter  (bad_filter)
  );

  always #5 clk = ~clk;

  stim_t      stim_q[$];
  pixel_res_t pixel_q[$];

  int n_total;   // stream bytes queued
  int n_in;      // stream bytes accepted
  int n_pred;    // results predicted
  int n_got;     // results checked
  int n_err;
  int third;
  int hold_at;
  int hold_left;
  bit hold_done;
  int quiet;
  int stall_cycles;

  // Generator's view of the raw register contents
  logic [11:0] gen_pix;
  logic [2:0]  gen_bpp;
  logic [15:0] gen_rows;

  // Predictor state
  logic [11:0] cur_pix;
  logic [2:0]  cur_bpp;
  logic [15:0] cur_rows;
  logic [7:0]  line_mem [0:STORE_DEPTH-1];
  logic [7:0]  left_hist [0:MAX_PIXEL_BYTES-1];
  logic [7:0]  up_left_hist [0:MAX_PIXEL_BYTES-1];
  filt_t       row_filt;
  bit          want_filt;
  logic [12:0] col_cnt;
  logic [15:0] row_cnt;
  bit          stopped;

  // Saturate the raw register values the way the block interprets them
  function automatic int pixels_per_row(input logic [11:0] v);
    if (v == 0) return 1;
    if (v > MAX_ROW_PIXELS) return MAX_ROW_PIXELS;
    return int'(v);
  endfunction

  function automatic int bytes_per_px(input logic [2:0] v);
    if (v == 0) return 1;
    if (v > MAX_PIXEL_BYTES) return MAX_PIXEL_BYTES;
    return int'(v);
  endfunction

  function automatic int rows_per_image(input logic [15:0] v);
    return (v == 0) ? 1 : int'(v);
  endfunction

  function automatic logic [7:0] paeth_choose(input logic [7:0] a, b, c);
    int da, db, dc;
    da = int'(b) - int'(c);
    db = int'(a) - int'(c);
    dc = int'(a) + int'(b) - 2 * int'(c);
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  function automatic int idle_phase();
    return (n_in < third) ? 0 : (n_in < 2 * third) ? 1 : 2;
  endfunction

  task automatic log_error(input string msg);
    n_err++;
    if (n_err <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic clear_predictor();
    cur_pix  = 12'd1;
    cur_bpp  = 3'd4;
    cur_rows = 16'd1;
    for (int i = 0; i < STORE_DEPTH; i++) line_mem[i] = '0;
    for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
      left_hist[i]    = '0;
      up_left_hist[i] = '0;
    end
    row_filt  = FILT_NONE;
    want_filt = 1'b1;
    col_cnt   = '0;
    row_cnt   = '0;
    stopped   = 1'b0;
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
    case (idx)
      CFG_ROW_PIXELS:      cur_pix  = val[11:0];
      CFG_BYTES_PER_PIXEL: cur_bpp  = val[2:0];
      CFG_IMAGE_ROWS:      cur_rows = val;
      default: ;
    endcase
  endtask

  // Reconstruct one accepted stream byte and queue the result it should give
  task automatic reconstruct_byte(input logic [7:0] x);
    pixel_res_t r;
    int         bpp, row_bytes, i;
    logic [7:0] a, b, c, p;
    if (stopped) return;
    r.pix  = '0;
    r.done = 1'b0;
    r.bad  = 1'b0;
    // Filter type byte: latch it, or halt on an illegal code
    if (want_filt) begin
      if (x > FILT_MAX_CODE) begin
        stopped = 1'b1;
        r.bad   = 1'b1;
        pixel_q.insert(pixel_q.size(), r);
        n_pred++;
      end else begin
        row_filt  = filt_t'(x[2:0]);
        want_filt = 1'b0;
      end
      return;
    end
    bpp       = bytes_per_px(cur_bpp);
    row_bytes = pixels_per_row(cur_pix) * bpp;
    a = (col_cnt >= bpp) ? left_hist[bpp-1] : 8'd0;
    b = (row_cnt != 0) ? line_mem[col_cnt] : 8'd0;
    c = (row_cnt != 0 && col_cnt >= bpp) ? up_left_hist[bpp-1] : 8'd0;
    case (row_filt)
      FILT_SUB:   p = a;
      FILT_UP:    p = b;
      FILT_AVG:   p = 8'((9'(a) + 9'(b)) >> 1);
      FILT_PAETH: p = paeth_choose(a, b, c);
      default:    p = 8'd0;
    endcase
    r.pix = x + p;
    // Shift the neighbour histories and update the line store
    for (i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
      left_hist[i]    = left_hist[i-1];
      up_left_hist[i] = up_left_hist[i-1];
    end
    left_hist[0]      = r.pix;
    up_left_hist[0]   = b;
    line_mem[col_cnt] = r.pix;
    // Advance column, row and image
    if (int'(col_cnt) + 1 >= row_bytes) begin
      col_cnt   = '0;
      want_filt = 1'b1;
      if (int'(row_cnt) + 1 >= rows_per_image(cur_rows)) begin
        row_cnt = '0;
        r.done  = 1'b1;
      end else begin
        row_cnt = row_cnt + 16'd1;
      end
    end else begin
      col_cnt = col_cnt + 13'd1;
    end
    pixel_q.insert(pixel_q.size(), r);
    n_pred++;
  endtask

  task automatic queue_reg(input logic [1:0] idx, input logic [15:0] val);
    stim_t s;
    s.is_reg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    s.data    = '0;
    stim_q.insert(stim_q.size(), s);
    case (idx)
      CFG_ROW_PIXELS:      gen_pix  = val[11:0];
      CFG_BYTES_PER_PIXEL: gen_bpp  = val[2:0];
      CFG_IMAGE_ROWS:      gen_rows = val;
      default: ;
    endcase
  endtask

  task automatic queue_byte(input logic [7:0] b);
    stim_t s;
    s.is_reg  = 1'b0;
    s.reg_idx = '0;
    s.reg_val = '0;
    s.data    = b;
    stim_q.insert(stim_q.size(), s);
    n_total++;
  endtask

  // Filter byte followed by one row of random data
  task automatic queue_row(input logic [7:0] filt);
    queue_byte(filt);
    repeat (pixels_per_row(gen_pix) * bytes_per_px(gen_bpp))
      queue_byte(8'($urandom_range(0, 255)));
  endtask

  // Random geometry at an image boundary, out-of-range values included
  task automatic queue_setup();
    logic [11:0] pix;
    logic [15:0] rows;
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 9))
        0:       pix = 12'd0;
        1:       pix = 12'($urandom_range(13, 32));
        default: pix = 12'($urandom_range(1, 12));
      endcase
      queue_reg(CFG_ROW_PIXELS, {4'($urandom), pix});
    end
    if ($urandom_range(0, 2) != 0)
      queue_reg(CFG_BYTES_PER_PIXEL, {13'($urandom), 3'($urandom_range(0, 7))});
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 9))
        0:       rows = 16'd0;
        1:       rows = 16'hFFFF;
        default: rows = 16'($urandom_range(1, 6));
      endcase
      queue_reg(CFG_IMAGE_ROWS, rows);
    end
  endtask

  // Rows of one image; image_rows may be rewritten between rows
  task automatic queue_image();
    int          rows_out, left;
    logic [15:0] nv;
    rows_out = 0;
    do begin
      queue_row(8'($urandom_range(0, 4)));
      rows_out++;
      left = rows_per_image(gen_rows) - rows_out;
      if (left > 0 && (left > 6 || $urandom_range(0, 3) == 0)) begin
        case ($urandom_range(0, 3))
          0:       nv = 16'd0;
          1:       nv = 16'hFFFF;
          2:       nv = 16'(rows_out + $urandom_range(0, 3));
          default: nv = 16'($urandom);
        endcase
        queue_reg(CFG_IMAGE_ROWS, nv);
      end
    end while (rows_out < rows_per_image(gen_rows));
  endtask

  // Sender: present queued transactions, register writes only once idle
  always @(posedge clk) begin : drive
    stim_t head;
    logic  nxt_in, nxt_cfg;
    int    sender_idle;
    if (rst) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
      n_in      <= 0;
      quiet     <= 0;
    end else begin
      nxt_in      = in_valid;
      nxt_cfg     = cfg_valid;
      sender_idle = (idle_phase() == 0) ? 31 : (idle_phase() == 1) ? 83 : 0;
      if (cfg_valid && cfg_ready) begin
        write_register(cfg_index, cfg_data);
        nxt_cfg = 1'b0;
      end
      if (in_valid && in_ready) begin
        reconstruct_byte(stream_byte);
        n_in   <= n_in + 1;
        nxt_in = 1'b0;
      end
      if (!nxt_in && !nxt_cfg && stim_q.size() != 0) begin
        head = stim_q[0];
        if (head.is_reg) begin
          if (quiet >= SETTLE_CYCLES && !in_valid && n_got == n_pred) begin
            cfg_index <= head.reg_idx;
            cfg_data  <= head.reg_val;
            nxt_cfg   = 1'b1;
            void'(stim_q.pop_front());
          end
        end else if ($urandom_range(0, 99) >= sender_idle) begin
          stream_byte <= head.data;
          nxt_in      = 1'b1;
          void'(stim_q.pop_front());
        end
      end
      // Count idle cycles so a register write waits out any trailing work
      if (in_valid || cfg_valid || n_got != n_pred) quiet <= 0;
      else if (quiet < SETTLE_CYCLES) quiet <= quiet + 1;
      in_valid  <= nxt_in;
      cfg_valid <= nxt_cfg;
    end
  end

  // Receiver: check each result against the oldest prediction
  always @(posedge clk) begin : receive
    pixel_res_t want;
    int         recv_idle;
    if (rst) begin
      out_ready <= 1'b0;
      n_got     <= 0;
    end else begin
      recv_idle = (idle_phase() == 0) ? 83 : (idle_phase() == 1) ? 31 : 0;
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          log_error($sformatf("unexpected result pixel_byte %02h image_done %0b bad_filter %0b",
                              pixel_byte, image_done, bad_filter));
        end else begin
          want  = pixel_q.pop_front();
          n_got <= n_got + 1;
          if (pixel_byte !== want.pix || image_done !== want.done || bad_filter !== want.bad)
            log_error($sformatf({"pixel_byte exp %02h got %02h, image_done exp %0b got %0b, ",
                                 "bad_filter exp %0b got %0b"}, want.pix, pixel_byte,
                                want.done, image_done, want.bad, bad_filter));
        end
      end
      out_ready <= (hold_left > 0) ? 1'b0 : ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Hold the receiver off once for a long stretch so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_in >= hold_at) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("** png_scanline_unfilter: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    n_total  = 0;
    n_pred   = 0;
    n_err    = 0;
    hold_at  = 0;
    gen_pix  = 12'd1;
    gen_bpp  = 3'd4;
    gen_rows = 16'd1;
    clear_predictor();

    // Reset geometry: one pixel of four bytes, Sub with no left neighbour
    queue_byte(8'(FILT_SUB));
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h80);
    queue_byte(8'h7F);
    // Two gray pixels per row, one row for each filter type
    queue_reg(CFG_ROW_PIXELS, 16'd2);
    queue_reg(CFG_BYTES_PER_PIXEL, 16'd1);
    queue_reg(CFG_IMAGE_ROWS, 16'd5);
    queue_byte(8'(FILT_NONE));
    queue_byte(8'hFF);
    queue_byte(8'h01);
    queue_byte(8'(FILT_SUB));
    queue_byte(8'hFF);
    queue_byte(8'h01);
    queue_byte(8'(FILT_UP));
    queue_byte(8'h80);
    queue_byte(8'h80);
    queue_byte(8'(FILT_AVG));
    queue_byte(8'hFF);
    queue_byte(8'hFF);
    queue_byte(8'(FILT_PAETH));
    queue_byte(8'h00);
    queue_byte(8'hFF);

    // Random images of small geometry
    while (n_total < ITEM_TARGET - TAIL_ITEMS) begin
      queue_setup();
      queue_image();
    end

    // Forty gray pixels over two rows, with the long receiver hold-off inside them
    queue_reg(CFG_ROW_PIXELS, 16'd40);
    queue_reg(CFG_BYTES_PER_PIXEL, 16'd1);
    queue_reg(CFG_IMAGE_ROWS, 16'd2);
    hold_at = n_total + 20;
    queue_row(8'($urandom_range(0, 4)));
    queue_row(8'(FILT_PAETH));
    // Upper register bits dropped and pixel size saturated to four bytes
    queue_reg(CFG_ROW_PIXELS, 16'hF003);
    queue_reg(CFG_BYTES_PER_PIXEL, 16'd7);
    queue_reg(CFG_IMAGE_ROWS, 16'd2);
    queue_row(8'($urandom_range(0, 4)));
    queue_row(8'(FILT_PAETH));
    // Illegal filter type, then input that must be dropped
    queue_byte(8'($urandom_range(5, 255)));
    queue_byte(8'h00);
    queue_byte(8'($urandom_range(0, 255)));
    queue_byte(8'hFF);
    third = n_total / 3;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Wait for all stimulus to go in and all results to come out
    while (stim_q.size() != 0 || in_valid || cfg_valid || n_got != n_pred) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pixel_q.size() != 0) log_error($sformatf("%0d results never arrived", pixel_q.size()));
    if (n_err == 0) $display("** png_scanline_unfilter: PASSED **");
    else $display("** png_scanline_unfilter: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
